// ===== rtl/core/tgdt_pkg.sv =====
// Shared types and constants for the tile group dedup table.
package tgdt_pkg;

    localparam int TILE_W     = 8;
    localparam int KEY_W      = 4 * TILE_W;
    localparam int INDEX_W    = 8;
    localparam int USED_W     = 9;
    localparam int S_TDATA_W  = KEY_W;
    localparam int M_TDATA_W  = 24;
    localparam int M_PAD_W    = M_TDATA_W - INDEX_W - USED_W;
    localparam int OUTCOME_W  = 2;

    typedef logic [OUTCOME_W-1:0] outcome_t;
    typedef logic [KEY_W-1:0]     group_key_t;

    // input kind
    localparam logic KIND_CLEAR = 1'b1;

    // result outcome codes
    localparam outcome_t OUT_FOUND    = 2'd0;
    localparam outcome_t OUT_INSERTED = 2'd1;
    localparam outcome_t OUT_FULL     = 2'd2;
    localparam outcome_t OUT_CLEARED  = 2'd3;

endpackage

// ===== rtl/core/tile_group_dedup_table.sv =====
// Top level: first-seen dictionary of 2x2 tile groups, scanned from a synchronous RAM.
// Flow: a clear, or a lookup into an empty table, goes from the idle state to the emit
//   state and on into the output register; a lookup into a table holding N groups scans
//   the stored groups through the table RAM's single read port (one stored group compared per cycle).
// Throughput: one item at a time; the output register lets
//   the next beat be taken while a result still waits on m_tready.
// Reset: the group count and all handshake state clear at once; the RAM is not cleared,
//   entries at or above the count are never read, so there is no clearing pass.
module tile_group_dedup_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // s_tdata, low bit up: tile_top_left[7:0], tile_top_right[15:8],
    //                      tile_bottom_left[23:16], tile_bottom_right[31:24]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tgdt_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: kind[0]
    input  logic                           s_tuser,
    // m_tdata, low bit up: group_index[7:0], entries_used[16:8], zero[23:17]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tgdt_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: outcome[1:0]
    output logic [tgdt_pkg::OUTCOME_W-1:0] m_tuser
);
    import tgdt_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // table RAM, one write and one registered read port
    group_key_t group_mem [TABLE_DEPTH];
    group_key_t rd_data_reg;
    logic              mem_re;
    logic              mem_we;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    group_key_t        wr_data;

    logic [1:0]        state_reg,   state_next;
    logic [ADDR_W-1:0] ptr_reg,     ptr_next;     // entry held in rd_data_reg
    logic [CNT_W-1:0]  count_reg,   count_next;
    group_key_t        key_reg,     key_next;

    // finished result waiting for the output register
    logic [ADDR_W-1:0] pend_index_reg,   pend_index_next;
    outcome_t          pend_outcome_reg, pend_outcome_next;
    logic [CNT_W-1:0]  pend_used_reg,    pend_used_next;

    // output register
    logic               m_tvalid_reg,    m_tvalid_next;
    logic [INDEX_W-1:0] out_index_reg,   out_index_next;
    outcome_t           out_outcome_reg, out_outcome_next;
    logic [USED_W-1:0]  out_used_reg,    out_used_next;

    logic [ADDR_W+INDEX_W-1:0] index_wide;
    logic [CNT_W+USED_W-1:0]   used_wide;
    logic [CNT_W-1:0]          ptr_inc;
    logic                      out_free;

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {{M_PAD_W{1'b0}}, out_used_reg, out_index_reg};
    assign m_tuser    = out_outcome_reg;

    assign index_wide = {{INDEX_W{1'b0}}, pend_index_reg};
    assign used_wide  = {{USED_W{1'b0}}, pend_used_reg};
    assign ptr_inc    = CNT_W'(ptr_reg) + 1'b1;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign wr_addr    = count_reg[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            group_mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= group_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        ptr_next          = ptr_reg;
        count_next        = count_reg;
        key_next          = key_reg;
        pend_index_next   = pend_index_reg;
        pend_outcome_next = pend_outcome_reg;
        pend_used_next    = pend_used_reg;
        mem_re            = 1'b0;
        mem_we            = 1'b0;
        rd_addr           = ptr_reg;
        wr_data           = key_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        out_index_next    = out_index_reg;
        out_outcome_next  = out_outcome_reg;
        out_used_next     = out_used_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == KIND_CLEAR)
                    begin
                        count_next        = '0;
                        pend_index_next   = '0;
                        pend_outcome_next = OUT_CLEARED;
                        pend_used_next    = '0;
                        state_next        = ST_EMIT;
                    end
                    else if (count_reg == '0)
                    begin
                        // empty table: append right away
                        mem_we            = 1'b1;
                        wr_data           = s_tdata;
                        count_next        = CNT_W'(1);
                        pend_index_next   = '0;
                        pend_outcome_next = OUT_INSERTED;
                        pend_used_next    = CNT_W'(1);
                        state_next        = ST_EMIT;
                    end
                    else
                    begin
                        key_next   = s_tdata;
                        mem_re     = 1'b1;
                        rd_addr    = '0;
                        ptr_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rd_data_reg == key_reg)
                begin
                    pend_index_next   = ptr_reg;
                    pend_outcome_next = OUT_FOUND;
                    pend_used_next    = count_reg;
                    state_next        = ST_EMIT;
                end
                else if (ptr_inc < count_reg)
                begin
                    mem_re   = 1'b1;
                    rd_addr  = ptr_inc[ADDR_W-1:0];
                    ptr_next = ptr_inc[ADDR_W-1:0];
                end
                else if (count_reg == CNT_W'(TABLE_DEPTH))
                begin
                    pend_index_next   = '0;
                    pend_outcome_next = OUT_FULL;
                    pend_used_next    = count_reg;
                    state_next        = ST_EMIT;
                end
                else
                begin
                    mem_we            = 1'b1;
                    count_next        = count_reg + 1'b1;
                    pend_index_next   = count_reg[ADDR_W-1:0];
                    pend_outcome_next = OUT_INSERTED;
                    pend_used_next    = count_reg + 1'b1;
                    state_next        = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next    = 1'b1;
                    out_index_next   = index_wide[INDEX_W-1:0];
                    out_outcome_next = pend_outcome_reg;
                    out_used_next    = used_wide[USED_W-1:0];
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        ptr_reg          <= ptr_next;
        key_reg          <= key_next;
        pend_index_reg   <= pend_index_next;
        pend_outcome_reg <= pend_outcome_next;
        pend_used_reg    <= pend_used_next;
        out_index_reg    <= out_index_next;
        out_outcome_reg  <= out_outcome_next;
        out_used_reg     <= out_used_next;
    end

`ifndef ASSERT_OFF
    // count never runs past the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("group count exceeds table depth");

    // scan pointer stays among stored entries
    a_scan_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CNT_W'(ptr_reg) < count_reg))
        else $error("scan pointer past stored entries");

    // appends only into free slots
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (count_reg < CNT_W'(TABLE_DEPTH)))
        else $error("append into full table");

    // a clear beat empties the table
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == KIND_CLEAR)) |=> (count_reg == '0))
        else $error("clear did not empty table");
`endif

endmodule

// ===== test/tgdt_check.sv =====
// Result checker for the tile group dedup table: predicts each result beat and compares it.
module tgdt_check #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [tgdt_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [tgdt_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [tgdt_pkg::OUTCOME_W-1:0] m_tuser,
    output int                             fail_count,
    output int                             pending,
    output int                             found_count,
    output int                             inserted_count,
    output int                             full_count,
    output int                             cleared_count
);
    import tgdt_pkg::*;

    typedef struct packed {
        logic [INDEX_W-1:0] group_index;
        outcome_t           outcome;
        logic [USED_W-1:0]  entries_used;
    } group_result_t;

    // shadow copy of the dictionary; entries at or above stored_count are never read
    group_key_t    stored_groups [TABLE_DEPTH];
    int            stored_count;
    group_result_t results_due [$];

    // first-seen lookup: hit, append, full, or clear
    function automatic group_result_t lookup_group(input logic kind, input group_key_t key);
        group_result_t r;
        int            hit;
        hit = -1;
        if (kind == KIND_CLEAR)
        begin
            stored_count   = 0;
            r.group_index  = '0;
            r.outcome      = OUT_CLEARED;
            r.entries_used = '0;
            return r;
        end
        for (int i = 0; i < stored_count; i++)
        begin
            if (hit < 0 && stored_groups[i] == key)
                hit = i;
        end
        if (hit >= 0)
        begin
            r.group_index = hit[INDEX_W-1:0];
            r.outcome     = OUT_FOUND;
        end
        else if (stored_count >= TABLE_DEPTH)
        begin
            r.group_index = '0;
            r.outcome     = OUT_FULL;
        end
        else
        begin
            stored_groups[stored_count] = key;
            r.group_index = stored_count[INDEX_W-1:0];
            r.outcome     = OUT_INSERTED;
            stored_count++;
        end
        r.entries_used = stored_count[USED_W-1:0];
        return r;
    endfunction

    task automatic report(input string field, input int want, input int got);
        fail_count++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin : watch
        group_result_t want;
        group_result_t got;
        if (!rst_n)
        begin
            stored_count   = 0;
            fail_count     = 0;
            found_count    = 0;
            inserted_count = 0;
            full_count     = 0;
            cleared_count  = 0;
            results_due.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.group_index  = m_tdata[INDEX_W-1:0];
                got.entries_used = m_tdata[INDEX_W +: USED_W];
                got.outcome      = m_tuser;
                if (results_due.size() == 0)
                begin
                    report("unexpected beat, outcome", -1, got.outcome);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got.group_index !== want.group_index)
                        report("group_index", want.group_index, got.group_index);
                    if (got.outcome !== want.outcome)
                        report("outcome", want.outcome, got.outcome);
                    if (got.entries_used !== want.entries_used)
                        report("entries_used", want.entries_used, got.entries_used);
                    if (m_tdata[M_TDATA_W-1:INDEX_W+USED_W] !== '0)
                        report("tdata pad", 0, m_tdata[M_TDATA_W-1:INDEX_W+USED_W]);
                    case (want.outcome)
                        OUT_FOUND:    found_count++;
                        OUT_INSERTED: inserted_count++;
                        OUT_FULL:     full_count++;
                        default:      cleared_count++;
                    endcase
                end
            end
            if (s_tvalid && s_tready)
                results_due.push_back(lookup_group(s_tuser, s_tdata));
        end
        pending = results_due.size();
    end

endmodule

// ===== test/tb_tile_group_dedup_table.sv =====
// Testbench top for the tile group dedup table: stimulus, handshake pressure and verdict.
module tb_tile_group_dedup_table;
    import tgdt_pkg::*;

    localparam int   TABLE_DEPTH = 256;
    localparam logic KIND_LOOKUP = 1'b0;
    localparam int   ITEM_TARGET = 1900;
    localparam int   MID_FILL_AT = 1100;
    // longest quiet stretch: long hold-off plus a full-table scan plus both gaps, taken ~5x
    localparam int   IDLE_LIMIT  = 4000;
    localparam int   LONG_HOLD   = 400;
    localparam int   HOLD_EVERY  = 700;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [OUTCOME_W-1:0]  m_tuser;

    int fail_count;
    int pending;
    int found_count;
    int inserted_count;
    int full_count;
    int cleared_count;

    int         items_sent;
    int         holds_done;
    int         fills_done;
    logic       tx_fast;
    group_key_t keys_live [$];   // groups offered since the last clear

    tile_group_dedup_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    tgdt_check #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .fail_count     (fail_count),
        .pending        (pending),
        .found_count    (found_count),
        .inserted_count (inserted_count),
        .full_count     (full_count),
        .cleared_count  (cleared_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // tdata carries top_left in the low byte
    function automatic group_key_t tiles(input logic [7:0] tl, input logic [7:0] tr,
                                         input logic [7:0] bl, input logic [7:0] br);
        return {br, bl, tr, tl};
    endfunction

    function automatic group_key_t live_key();
        return keys_live[$urandom_range(0, keys_live.size() - 1)];
    endfunction

    // one beat on the input side, after a random gap with noise on the idle bus
    task automatic send_item(input logic kind, input group_key_t key);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 10);
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 1'($urandom);
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
        items_sent++;
        if (kind == KIND_CLEAR)
            keys_live.delete();
        else
            keys_live.push_back(key);
    endtask

    // sender goes quiet until every expected result beat has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // clear, overfill, then mix stored groups with unknown ones against a full table
    task automatic fill_table();
        tx_fast = 1'b0;
        send_item(KIND_CLEAR, $urandom);
        repeat (TABLE_DEPTH + 40)
            send_item(KIND_LOOKUP, $urandom);
        repeat (60)
        begin
            case ($urandom_range(0, 2))
                0:       send_item(KIND_LOOKUP, keys_live[$urandom_range(0, TABLE_DEPTH - 1)]);
                1:       send_item(KIND_LOOKUP, keys_live[$urandom_range(0, TABLE_DEPTH - 1)]
                                                ^ (32'h1 << $urandom_range(0, 31)));
                default: send_item(KIND_LOOKUP, $urandom);
            endcase
        end
        fills_done++;
        drain_results();
    endtask

    // episodes of lookups after a clear: repeats, near misses, tiny alphabets, fresh groups
    task automatic random_episodes(input int stop_at);
        int len;
        int pick;
        while (items_sent < stop_at)
        begin
            tx_fast = ($urandom_range(0, 3) == 0);
            send_item(KIND_CLEAR, $urandom);
            len = $urandom_range(5, 150);
            repeat (len)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    send_item(KIND_CLEAR, $urandom);
                else if (pick < 50 && keys_live.size() > 0)
                    send_item(KIND_LOOKUP, live_key());
                else if (pick < 58 && keys_live.size() > 0)
                    send_item(KIND_LOOKUP, live_key() ^ (32'h1 << $urandom_range(0, 31)));
                else if (pick < 66)
                    send_item(KIND_LOOKUP,
                              tiles(8'($urandom_range(0, 1)), 8'($urandom_range(0, 1)),
                                    8'($urandom_range(0, 1)), 8'($urandom_range(0, 1))));
                else
                    send_item(KIND_LOOKUP, $urandom);
            end
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end
    endtask

    // result side: random stall per beat, fast stretches, and a long hold-off now and then
    initial
    begin : result_sink
        int   wait_left;
        int   rx_beats;
        logic rx_fast;
        m_tready   = 1'b0;
        wait_left  = 0;
        rx_beats   = 0;
        rx_fast    = 1'b0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                rx_beats++;
                if (rx_beats % HOLD_EVERY == 0)
                begin
                    wait_left = LONG_HOLD;
                    holds_done++;
                end
                else
                begin
                    wait_left = rx_fast ? 0 : $urandom_range(0, 10);
                end
                if (rx_beats % 64 == 0)
                    rx_fast = ($urandom_range(0, 2) == 0);
            end
            else if (wait_left > 0)
            begin
                wait_left--;
            end
            m_tready <= rst_n && (wait_left == 0);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles, %0d results outstanding",
                         $time, quiet, pending);
                $display("** tile_group_dedup_table: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = KIND_LOOKUP;
        items_sent = 0;
        fills_done = 0;
        tx_fast    = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tile extremes, hits, clears on non-empty and empty tables, reuse after clear
        send_item(KIND_LOOKUP, tiles(8'h00, 8'h00, 8'h00, 8'h00));
        send_item(KIND_LOOKUP, tiles(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_item(KIND_LOOKUP, tiles(8'h00, 8'h00, 8'h00, 8'h00));
        send_item(KIND_LOOKUP, tiles(8'hFF, 8'h00, 8'h00, 8'h00));
        send_item(KIND_LOOKUP, tiles(8'h00, 8'hFF, 8'h00, 8'h00));
        send_item(KIND_LOOKUP, tiles(8'h00, 8'h00, 8'hFF, 8'h00));
        send_item(KIND_LOOKUP, tiles(8'h00, 8'h00, 8'h00, 8'hFF));
        send_item(KIND_LOOKUP, tiles(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_item(KIND_CLEAR, '1);
        send_item(KIND_CLEAR, '0);
        // old entries must not be visible once cleared
        send_item(KIND_LOOKUP, tiles(8'h00, 8'h00, 8'h00, 8'hFF));
        send_item(KIND_LOOKUP, tiles(8'h00, 8'h00, 8'h00, 8'h00));
        send_item(KIND_LOOKUP, tiles(8'h80, 8'h80, 8'h80, 8'h80));
        send_item(KIND_LOOKUP, tiles(8'h7F, 8'h7F, 8'h7F, 8'h7F));
        send_item(KIND_LOOKUP, tiles(8'h01, 8'h02, 8'h03, 8'h04));
        send_item(KIND_LOOKUP, tiles(8'h04, 8'h03, 8'h02, 8'h01));
        send_item(KIND_LOOKUP, tiles(8'h01, 8'h02, 8'h03, 8'h04));
        send_item(KIND_LOOKUP, tiles(8'h00, 8'h00, 8'h00, 8'h00));
        drain_results();

        fill_table();
        random_episodes(MID_FILL_AT);
        fill_table();
        random_episodes(ITEM_TARGET);

        drain_results();
        repeat (TABLE_DEPTH + 10) @(posedge clk);

        $display("Sent %0d items: %0d found, %0d inserted, %0d table full, %0d clears",
                 items_sent, found_count, inserted_count, full_count, cleared_count);
        $display("Filled the table %0d times; %0d long result hold-offs of %0d cycles",
                 fills_done, holds_done, LONG_HOLD);
        if (fail_count == 0)
            $display("** tile_group_dedup_table: PASSED **");
        else
            $display("** tile_group_dedup_table: FAILED **");
        $finish;
    end

endmodule
